FILE: hw/rtl/camera_pose_packet_encoder_top_defines.svh
// Assertion macros shared by the camera pose packet encoder RTL.
`ifndef CAMERA_POSE_PACKET_ENCODER_TOP_DEFINES_SVH
`define CAMERA_POSE_PACKET_ENCODER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CPPE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cppe check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CPPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cppe check failed");

`endif

FILE: hw/rtl/cppe_pkg.sv
// Package with types, constants and helper functions of the camera pose packet encoder.
package cppe_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_CAMERA_NUMBER = 0;

    localparam int PKT_IDX_W = 5;
    localparam logic [PKT_IDX_W-1:0] TYPE_IDX = 5'd0;
    localparam logic [PKT_IDX_W-1:0] CAM_IDX = 5'd1;
    localparam logic [PKT_IDX_W-1:0] FIELD_FIRST_IDX = 5'd2;
    localparam logic [PKT_IDX_W-1:0] FIELD_LAST_IDX = 5'd19;
    localparam logic [PKT_IDX_W-1:0] PKT_LAST_IDX = 5'd28;

    localparam logic [7:0] PKT_TYPE = 8'hD1;
    localparam logic [7:0] CKSUM_SEED = 8'h40;
    localparam logic signed [16:0] POS_SCALE = 17'sd64000;
    localparam logic signed [32:0] S24_LO = -33'sd8388608;
    localparam logic signed [32:0] S24_HI = 33'sd8388607;
    localparam int PKT_FIELD_BITS = 144;

    typedef struct packed {
        logic signed [31:0] pan_angle;
        logic signed [31:0] tilt_angle;
        logic signed [31:0] roll_angle;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } pose_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } pkt_out_t;

    typedef struct packed {
        logic [23:0] pan;
        logic [23:0] tilt;
        logic [23:0] roll;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } pkt_fields_t;

    function automatic logic [23:0] sat24(input logic signed [32:0] v);
        logic [23:0] res;
        if (v < S24_LO)
        begin
            res = 24'h800000;
        end
        else if (v > S24_HI)
        begin
            res = 24'h7FFFFF;
        end
        else
        begin
            res = v[23:0];
        end
        return res;
    endfunction

    // Rounds a product with 16 fraction bits half away from zero.
    function automatic logic signed [32:0] round_pos(input logic signed [47:0] p);
        logic        neg;
        logic [47:0] mag;
        logic [47:0] biased;
        logic [32:0] r;
        neg = p[47];
        mag = neg ? 48'(-p) : 48'(p);
        biased = mag + 48'd32768;
        r = {1'b0, biased[47:16]};
        return neg ? signed'(33'(-r)) : signed'(r);
    endfunction

endpackage

FILE: hw/rtl/cppe_cfg.sv
// Configuration register file holding the camera number.
module cppe_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cppe_pkg::PADDR_W-1:0]  paddr,
    input  logic [cppe_pkg::PDATA_W-1:0]  pwdata,
    output logic [cppe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [7:0]                    camera_number
);
    import cppe_pkg::*;

    logic [7:0] cam_reg;
    logic       hit;

    assign hit = (paddr[PADDR_W-1:2] == 1'(REG_CAMERA_NUMBER));
    assign pready = 1'b1;
    assign prdata = hit ? {24'd0, cam_reg} : '0;
    assign camera_number = cam_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg <= '0;
        end
        else if (psel && penable && pwrite && hit)
        begin
            cam_reg <= pwdata[7:0];
        end
    end

endmodule

FILE: hw/rtl/cppe_scale.sv
// Front pipeline: input register, product register and saturated field register.
module cppe_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cppe_pkg::pose_t       in_data,
    output logic                  pkt_valid,
    input  logic                  pkt_stall,
    output cppe_pkg::pkt_fields_t pkt_data
);
    import cppe_pkg::*;

    logic               a_valid_reg;
    pose_t              a_pose_reg;
    logic               b_valid_reg;
    logic [23:0]        b_pan_reg;
    logic [23:0]        b_tilt_reg;
    logic [23:0]        b_roll_reg;
    logic signed [47:0] b_px_reg;
    logic signed [47:0] b_py_reg;
    logic signed [47:0] b_pz_reg;
    logic               c_valid_reg;
    pkt_fields_t        c_fields_reg;

    logic a_open;
    logic b_open;
    logic c_open;
    logic signed [47:0] px_next;
    logic signed [47:0] py_next;
    logic signed [47:0] pz_next;
    pkt_fields_t fields_next;

    assign c_open = !c_valid_reg || !pkt_stall;
    assign b_open = !b_valid_reg || c_open;
    assign a_open = !a_valid_reg || b_open;
    assign in_stall = !a_open;
    assign pkt_valid = c_valid_reg;
    assign pkt_data = c_fields_reg;

    always_comb
    begin
        px_next = a_pose_reg.pos_x * POS_SCALE;
        py_next = a_pose_reg.pos_y * POS_SCALE;
        pz_next = a_pose_reg.pos_z * POS_SCALE;
        fields_next.pan = b_pan_reg;
        fields_next.tilt = b_tilt_reg;
        fields_next.roll = b_roll_reg;
        fields_next.x = sat24(round_pos(b_px_reg));
        fields_next.y = sat24(round_pos(b_py_reg));
        fields_next.z = sat24(round_pos(b_pz_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_open)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_open)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_open)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_open && in_valid)
        begin
            a_pose_reg <= in_data;
        end
        if (b_open && a_valid_reg)
        begin
            b_pan_reg <= sat24(33'(a_pose_reg.pan_angle));
            b_tilt_reg <= sat24(33'(a_pose_reg.tilt_angle));
            b_roll_reg <= sat24(33'(a_pose_reg.roll_angle));
            b_px_reg <= px_next;
            b_py_reg <= py_next;
            b_pz_reg <= pz_next;
        end
        if (c_open && b_valid_reg)
        begin
            c_fields_reg <= fields_next;
        end
    end

endmodule

FILE: hw/rtl/cppe_ser.sv
// Packet serializer with running checksum and output register.
module cppe_ser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            camera_number,
    input  logic                  pkt_valid,
    output logic                  pkt_stall,
    input  cppe_pkg::pkt_fields_t pkt_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cppe_pkg::pkt_out_t    out_data
);
    import cppe_pkg::*;

    logic                 busy_reg;
    logic [PKT_IDX_W-1:0] idx_reg;
    logic [7:0]           sum_reg;
    pkt_fields_t          fields_reg;
    logic                 out_valid_reg;
    pkt_out_t             out_data_reg;

    logic                      slot_open;
    logic                      emit;
    logic                      at_last;
    logic                      pkt_load;
    logic [PKT_IDX_W-1:0]      off;
    logic [PKT_FIELD_BITS-1:0] fvec;
    logic [7:0]                cur_byte;

    assign slot_open = !out_valid_reg || !out_stall;
    assign emit = busy_reg && slot_open;
    assign at_last = (idx_reg == PKT_LAST_IDX);
    assign pkt_stall = busy_reg && !(emit && at_last);
    assign pkt_load = pkt_valid && !pkt_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign off = idx_reg - FIELD_FIRST_IDX;
    assign fvec = fields_reg;

    always_comb
    begin
        if (at_last)
        begin
            cur_byte = CKSUM_SEED - sum_reg;
        end
        else if (idx_reg == TYPE_IDX)
        begin
            cur_byte = PKT_TYPE;
        end
        else if (idx_reg == CAM_IDX)
        begin
            cur_byte = camera_number;
        end
        else if (idx_reg inside {[FIELD_FIRST_IDX:FIELD_LAST_IDX]})
        begin
            cur_byte = fvec[8'(PKT_FIELD_BITS - 1) - {off, 3'b000} -: 8];
        end
        else
        begin
            cur_byte = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
            sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (slot_open)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pkt_load)
            begin
                busy_reg <= 1'b1;
                idx_reg <= '0;
                sum_reg <= '0;
            end
            else if (emit)
            begin
                busy_reg <= !at_last;
                idx_reg <= idx_reg + 1'b1;
                sum_reg <= sum_reg + cur_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_load)
        begin
            fields_reg <= pkt_data;
        end
        if (emit)
        begin
            out_data_reg.packet_byte <= cur_byte;
            out_data_reg.last_byte <= at_last;
        end
    end

endmodule

FILE: hw/rtl/camera_pose_packet_encoder_top.sv
// Top level of the camera pose packet encoder.
// Each accepted pose becomes one 29-byte tracking packet, sent one byte per transfer
// with last_byte high on the checksum byte. The byte serializer sets the rate, and
// when the output never stalls, packets follow each other with no gap. A pose
// passes an input register, a register after the position multipliers and a
// register of saturated fields; when the serializer is free, the first byte of its
// packet then goes out through the serializer's output register, and up to
// three further poses are taken while a packet is still going out. The camera number
// is read from the register port at byte address 0 and should be written only while
// no packet is in flight.
`include "camera_pose_packet_encoder_top_defines.svh"

module camera_pose_packet_encoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cppe_pkg::PADDR_W-1:0]  paddr,
    input  logic [cppe_pkg::PDATA_W-1:0]  pwdata,
    output logic [cppe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  cppe_pkg::pose_t               in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cppe_pkg::pkt_out_t            out_data
);
    import cppe_pkg::*;

    logic        [7:0] camera_number;
    logic              pkt_valid;
    logic              pkt_stall;
    pkt_fields_t       pkt_data;
    logic              out_last;

    assign out_last = out_valid && out_data.last_byte;

    cppe_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .camera_number (camera_number)
    );

    cppe_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt_data  (pkt_data)
    );

    cppe_ser u_ser (
        .clk           (clk),
        .rst_n         (rst_n),
        .camera_number (camera_number),
        .pkt_valid     (pkt_valid),
        .pkt_stall     (pkt_stall),
        .pkt_data      (pkt_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

    // Two packet ends never come out back to back.
    `CPPE_ASSERT_NEXT(a_no_double_last, out_last && !out_stall, !out_last)
    // A packet taken by the serializer blocks the next one while its bytes go out.
    `CPPE_ASSERT_NEXT(a_one_pkt_at_a_time, pkt_valid && !pkt_stall, pkt_stall || !pkt_valid)
    // A stalled packet stays offered until the serializer takes it.
    `CPPE_ASSERT_NEXT(a_pkt_stall_holds_valid, pkt_valid && pkt_stall, pkt_valid)

endmodule
